/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled at every rising edge of clk, off while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// implication checked in the next cycle
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (prop)) else $error(msg);

`endif

/* rtl/ham_pkg.sv */
// ----------------------------------------------------------------------------
// ham_pkg
// Types, codes and constant helpers shared by the Hamming encode/check block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ham_pkg;

    // fixed field widths
    localparam int DATA_W = 26;
    localparam int CODE_W = 32;
    localparam int CFG_W  = 5;

    // request codes
    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_CHECK  = 1'b1;

    // register indexes
    localparam logic CFG_DATA_LENGTH = 1'b0;
    localparam logic CFG_ODD_PARITY  = 1'b1;

    // smallest data length honored
    localparam int MIN_DATA_BITS = 3;

    // control that travels with each beat between stages
    typedef struct packed {
        logic       valid;
        logic       is_check;
        logic       odd;
        logic [2:0] r;
    } ham_ctl_t;

    // smallest r with 2^r >= d + r + 1
    function automatic int calc_check_bits(int d);
        int r;
        r = 0;
        while (r < 7 && (1 << r) < d + r + 1)
            r = r + 1;
        return r;
    endfunction

    // floor of log2 for a positive value
    function automatic int flog2(int p);
        int v;
        int l;
        v = p;
        l = 0;
        while (v > 1)
        begin
            v = v >> 1;
            l = l + 1;
        end
        return l;
    endfunction

endpackage

/* rtl/ham_scatter.sv */
// ----------------------------------------------------------------------------
// ham_scatter
// First stage: places data bits or received bits onto codeword positions
// and masks off positions beyond the configured codeword length
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ham_scatter #(
    parameter int MAX_DATA_BITS = 26
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic                         req_type,
    input  logic [ham_pkg::DATA_W-1:0]   data_word,
    input  logic [ham_pkg::CODE_W-1:0]   received_code,
    input  logic [ham_pkg::CFG_W-1:0]    data_length,
    input  logic                         odd_parity,
    output ham_pkg::ham_ctl_t            ctl,
    output logic [MAX_DATA_BITS + ham_pkg::calc_check_bits(MAX_DATA_BITS) - 1:0] cw
);
    import ham_pkg::*;

    localparam int NPOS = MAX_DATA_BITS + calc_check_bits(MAX_DATA_BITS);
    localparam int DW   = $clog2(MAX_DATA_BITS + 1);

    logic [DW-1:0]   d_eff;
    logic [2:0]      r_cur;
    logic [7:0]      n_cur;
    logic [NPOS-1:0] pos_mask;
    logic [NPOS-1:0] enc_bits;
    logic [NPOS-1:0] chk_bits;
    logic [NPOS-1:0] cw_next;
    ham_ctl_t        ctl_next;
    ham_ctl_t        ctl_reg;
    logic [NPOS-1:0] cw_reg;

    // clamp the configured length into the supported range
    always_comb
    begin
        if (data_length < CFG_W'(MIN_DATA_BITS))
            d_eff = DW'(MIN_DATA_BITS);
        else if (32'(data_length) > 32'(MAX_DATA_BITS))
            d_eff = DW'(MAX_DATA_BITS);
        else
            d_eff = DW'(data_length);
    end

    // number of check bits, at most seven short steps
    always_comb
    begin
        r_cur = 3'd0;
        for (int i = 0; i < 7; i++)
        begin
            if ((8'd1 << r_cur) < (8'(d_eff) + 8'(r_cur) + 8'd1))
                r_cur = r_cur + 3'd1;
        end
        n_cur = 8'(d_eff) + 8'(r_cur);
    end

    // fixed scatter map and length mask per position
    for (genvar i = 0; i < NPOS; i++)
    begin : g_pos
        localparam int P = i + 1;
        localparam int J = P - 2 - flog2(P);

        assign pos_mask[i] = (8'(P) <= n_cur);

        if ((P & (P - 1)) == 0)
        begin : g_check_pos
            assign enc_bits[i] = 1'b0;
        end
        else if (J < DATA_W)
        begin : g_data_pos
            assign enc_bits[i] = data_word[J];
        end
        else
        begin : g_no_data
            assign enc_bits[i] = 1'b0;
        end

        if (i < CODE_W)
        begin : g_rx
            assign chk_bits[i] = received_code[i];
        end
        else
        begin : g_no_rx
            assign chk_bits[i] = 1'b0;
        end
    end

    // select by request type
    always_comb
    begin
        cw_next           = ((req_type == REQ_CHECK) ? chk_bits : enc_bits) & pos_mask;
        ctl_next.valid    = in_valid;
        ctl_next.is_check = (req_type == REQ_CHECK);
        ctl_next.odd      = odd_parity;
        ctl_next.r        = r_cur;
    end

    // stage register, control reset only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            cw_reg <= cw_next;
    end

    assign ctl = ctl_reg;
    assign cw  = cw_reg;

endmodule

/* rtl/ham_parity.sv */
// ----------------------------------------------------------------------------
// ham_parity
// Second stage: XOR tree per parity group over the masked codeword
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ham_parity #(
    parameter int MAX_DATA_BITS = 26
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  ham_pkg::ham_ctl_t   ctl_in,
    input  logic [MAX_DATA_BITS + ham_pkg::calc_check_bits(MAX_DATA_BITS) - 1:0] cw_in,
    output ham_pkg::ham_ctl_t   ctl,
    output logic [MAX_DATA_BITS + ham_pkg::calc_check_bits(MAX_DATA_BITS) - 1:0] cw,
    output logic [ham_pkg::calc_check_bits(MAX_DATA_BITS)-1:0] grp
);
    import ham_pkg::*;

    localparam int RMAX = calc_check_bits(MAX_DATA_BITS);
    localparam int NPOS = MAX_DATA_BITS + RMAX;

    logic [NPOS-1:0] grp_mask [RMAX];
    logic [RMAX-1:0] grp_next;
    ham_ctl_t        ctl_reg;
    logic [NPOS-1:0] cw_reg;
    logic [RMAX-1:0] grp_reg;

    // group k covers positions whose one-based number (i + 1) has bit k set
    for (genvar k = 0; k < RMAX; k++)
    begin : g_grp
        for (genvar i = 0; i < NPOS; i++)
        begin : g_bit
            assign grp_mask[k][i] = (((i + 1) >> k) & 1) != 0;
        end
        assign grp_next[k] = ^(cw_in & grp_mask[k]);
    end

    // stage register, control reset only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cw_reg  <= cw_in;
            grp_reg <= grp_next;
        end
    end

    assign ctl = ctl_reg;
    assign cw  = cw_reg;
    assign grp = grp_reg;

endmodule

/* rtl/ham_merge.sv */
// ----------------------------------------------------------------------------
// ham_merge
// Third stage: inserts check bits for encode, reduces group errors for check,
// and holds the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ham_merge #(
    parameter int MAX_DATA_BITS = 26
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  ham_pkg::ham_ctl_t   ctl_in,
    input  logic [MAX_DATA_BITS + ham_pkg::calc_check_bits(MAX_DATA_BITS) - 1:0] cw_in,
    input  logic [ham_pkg::calc_check_bits(MAX_DATA_BITS)-1:0] grp_in,
    output logic                out_valid,
    output logic [ham_pkg::CODE_W-1:0] code_word,
    output logic                error_found
);
    import ham_pkg::*;

    localparam int RMAX = calc_check_bits(MAX_DATA_BITS);
    localparam int NPOS = MAX_DATA_BITS + RMAX;

    logic [NPOS-1:0]   full_cw;
    logic [CODE_W-1:0] full_cw32;
    logic [RMAX-1:0]   act;
    logic              err;
    logic              out_valid_reg;
    logic [CODE_W-1:0] code_word_reg;
    logic              error_found_reg;

    // groups in use for this length
    for (genvar k = 0; k < RMAX; k++)
    begin : g_act
        assign act[k] = (ctl_in.r > 3'(k));
    end

    // check bit goes into each power-of-two position
    for (genvar i = 0; i < NPOS; i++)
    begin : g_full
        localparam int P = i + 1;
        if ((P & (P - 1)) == 0)
        begin : g_chk
            assign full_cw[i] = cw_in[i] |
                (act[flog2(P)] & (grp_in[flog2(P)] ^ ctl_in.odd));
        end
        else
        begin : g_dat
            assign full_cw[i] = cw_in[i];
        end
    end

    // fit to the output width
    for (genvar i = 0; i < CODE_W; i++)
    begin : g_out
        if (i < NPOS)
        begin : g_in
            assign full_cw32[i] = full_cw[i];
        end
        else
        begin : g_pad
            assign full_cw32[i] = 1'b0;
        end
    end

    // any active group off its expected parity
    assign err = |((grp_in ^ {RMAX{ctl_in.odd}}) & act);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= ctl_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            code_word_reg   <= ctl_in.is_check ? '0 : full_cw32;
            error_found_reg <= ctl_in.is_check & err;
        end
    end

    assign out_valid   = out_valid_reg;
    assign code_word   = code_word_reg;
    assign error_found = error_found_reg;

endmodule

/* rtl/hamming_code_encode_check.sv */
// An accepted input beat passes the scatter, parity and merge registers in turn.
// Throughput: one beat per cycle; a stalled output holds the whole pipeline.
// The rate is set by the three-stage scatter, parity-tree and merge pipeline.
// Reset: rst_n clears all valid bits, data_length to 4 and odd_parity to 0.
// ----------------------------------------------------------------------------
// hamming_code_encode_check
// Hamming encoder and checker with configurable data length and parity sense
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hamming_code_encode_check #(
    parameter int MAX_DATA_BITS = 26
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [ham_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        req_type,
    input  logic [ham_pkg::DATA_W-1:0]  data_word,
    input  logic [ham_pkg::CODE_W-1:0]  received_code,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ham_pkg::CODE_W-1:0]  code_word,
    output logic                        error_found
);
    import ham_pkg::*;

    localparam int RMAX = calc_check_bits(MAX_DATA_BITS);
    localparam int NPOS = MAX_DATA_BITS + RMAX;

    logic [CFG_W-1:0] data_length_reg;
    logic             odd_parity_reg;
    logic             pipe_en;
    ham_ctl_t         s1_ctl;
    ham_ctl_t         s2_ctl;
    logic [NPOS-1:0]  s1_cw;
    logic [NPOS-1:0]  s2_cw;
    logic [RMAX-1:0]  s2_grp;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_length_reg <= CFG_W'(4);
            odd_parity_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DATA_LENGTH: data_length_reg <= cfg_data;
                CFG_ODD_PARITY:  odd_parity_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline advances unless the output beat is stuck
    assign pipe_en  = !out_valid || out_ready;
    assign in_ready = pipe_en;

    ham_scatter #(
        .MAX_DATA_BITS (MAX_DATA_BITS)
    ) u_scatter (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (pipe_en),
        .in_valid      (in_valid),
        .req_type      (req_type),
        .data_word     (data_word),
        .received_code (received_code),
        .data_length   (data_length_reg),
        .odd_parity    (odd_parity_reg),
        .ctl           (s1_ctl),
        .cw            (s1_cw)
    );

    ham_parity #(
        .MAX_DATA_BITS (MAX_DATA_BITS)
    ) u_parity (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (pipe_en),
        .ctl_in (s1_ctl),
        .cw_in  (s1_cw),
        .ctl    (s2_ctl),
        .cw     (s2_cw),
        .grp    (s2_grp)
    );

    ham_merge #(
        .MAX_DATA_BITS (MAX_DATA_BITS)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (pipe_en),
        .ctl_in      (s2_ctl),
        .cw_in       (s2_cw),
        .grp_in      (s2_grp),
        .out_valid   (out_valid),
        .code_word   (code_word),
        .error_found (error_found)
    );

    // a valid beat moves one stage per enabled cycle
    `ASSERT_NEXT(a_s1_to_s2, s1_ctl.valid && pipe_en, s2_ctl.valid, "stage 1 beat lost")
    `ASSERT_NEXT(a_s2_to_out, s2_ctl.valid && pipe_en, out_valid, "stage 2 beat lost")
    // a check result never carries a codeword
    `ASSERT_CLK(a_err_no_code, !(out_valid && error_found) || code_word == '0, "check with code")

endmodule
